/* design/lctcg_pkg.sv */
// shared types, constants and helpers for the text-mode lcd character writer
// no dependencies; imported by every module of the block
package lctcg_pkg;

  // controller address width and bus byte width
  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;

  // default depth of the queue between front and back
  localparam int FIFO_DEPTH_DEF = 2;

  // configuration port widths
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_HOME      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTR_HOME      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTR_MODE      = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_ATTR_ONLY = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK          = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOLD           = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE        = 8'd7;

  localparam logic [7:0] ROW_WIDTH_RST = 8'd30;

  // controller commands
  localparam logic [7:0] CMD_ADDR_SET   = 8'h24;
  localparam logic [7:0] CMD_DATA_WRITE = 8'hC0;

  // character codes
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] GLYPH_OFFSET = 8'h20;
  localparam logic [7:0] CHAR_HIGH    = 8'h80;
  localparam logic [7:0] TAB_STEP     = 8'd3;

  // input opcodes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  // attribute codes
  localparam logic [7:0] ATTR_REV_BLINK  = 8'h0D;
  localparam logic [7:0] ATTR_REV        = 8'h05;
  localparam logic [7:0] ATTR_BOLD_BLINK = 8'h0F;
  localparam logic [7:0] ATTR_BOLD       = 8'h07;
  localparam logic [7:0] ATTR_BLINK      = 8'h08;
  localparam logic [7:0] ATTR_NONE       = 8'h00;

  // configuration as seen by front and back
  typedef struct packed {
    logic [ADDR_W-1:0] text_home;
    logic [ADDR_W-1:0] attr_home;
    logic [7:0]        row_width;
    logic              attr_en;
    logic [7:0]        attr_byte;
  } cfg_t;

  // one printable character handed from front to back
  typedef struct packed {
    logic [ADDR_W-1:0] offs;
    logic [7:0]        glyph;
    logic              with_attr;
  } job_t;

  // attribute byte from the selected attribute bits
  function automatic logic [7:0] attr_code(input logic reverse, input logic bold,
                                           input logic blink);
    logic [7:0] code;
    if (reverse) begin
      code = blink ? ATTR_REV_BLINK : ATTR_REV;
    end else if (bold && blink) begin
      code = ATTR_BOLD_BLINK;
    end else if (bold) begin
      code = ATTR_BOLD;
    end else if (blink) begin
      code = ATTR_BLINK;
    end else begin
      code = ATTR_NONE;
    end
    return code;
  endfunction

endpackage

/* design/lcd_text_char_command_gen.sv */
// top level of the text-mode lcd character writer: config registers and wiring
// depends on lctcg_pkg, lctcg_front, lctcg_fifo and lctcg_back
//
//   channel  handshake               payload
//   in       in_valid / in_stall     in_opcode, in_char_code, in_target_col, in_target_row
//   out      out_valid / out_stall   out_bus_byte, out_is_command, out_last_of_run
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a printable character produces 5 bus beats, or 13 with attribute writes, one per
// cycle while out_stall is low; the back-end byte sequencer sets the rate. control
// characters and cursor moves are handled in the front end and produce no beats.
// the front end stalls only when the job queue is full; the back end stalls only on
// out_stall. reset is synchronous: cursor at column 0 row 0, row width 30, other config registers 0.
module lcd_text_char_command_gen #(
  parameter int FIFO_DEPTH = lctcg_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [7:0]                       in_char_code,
  input  logic [7:0]                       in_target_col,
  input  logic [7:0]                       in_target_row,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_bus_byte,
  output logic                             out_is_command,
  output logic                             out_last_of_run,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lctcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lctcg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lctcg_pkg::*;

  logic [ADDR_W-1:0] text_home_r;
  logic [ADDR_W-1:0] attr_home_r;
  logic [7:0]        row_width_r;
  logic              attr_mode_r;
  logic              area_only_r;
  logic              blink_r;
  logic              bold_r;
  logic              reverse_r;
  cfg_t              cfg;
  logic              in_accept;
  logic              push;
  job_t              push_job;
  logic              pop;
  logic              full;
  logic              head_valid;
  job_t              head_job;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_home_r <= '0;
      attr_home_r <= '0;
      row_width_r <= ROW_WIDTH_RST;
      attr_mode_r <= 1'b0;
      area_only_r <= 1'b0;
      blink_r     <= 1'b0;
      bold_r      <= 1'b0;
      reverse_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEXT_HOME:      text_home_r <= cfg_data[ADDR_W-1:0];
        REG_ATTR_HOME:      attr_home_r <= cfg_data[ADDR_W-1:0];
        REG_ROW_WIDTH:      row_width_r <= cfg_data[7:0];
        REG_ATTR_MODE:      attr_mode_r <= cfg_data[0];
        REG_AREA_ATTR_ONLY: area_only_r <= cfg_data[0];
        REG_BLINK:          blink_r     <= cfg_data[0];
        REG_BOLD:           bold_r      <= cfg_data[0];
        REG_REVERSE:        reverse_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // configuration view for front and back
  always_comb begin
    cfg.text_home = text_home_r;
    cfg.attr_home = attr_home_r;
    cfg.row_width = row_width_r;
    cfg.attr_en   = attr_mode_r && !area_only_r;
    cfg.attr_byte = attr_code(reverse_r, bold_r, blink_r);
  end

  lctcg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_accept     (in_accept),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_target_col (in_target_col),
    .in_target_row (in_target_row),
    .push          (push),
    .push_job      (push_job)
  );

  lctcg_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  lctcg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_bus_byte    (out_bus_byte),
    .out_is_command  (out_is_command),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* design/lctcg_front.sv */
// front end: accepts input beats, keeps the cursor, classifies characters
// depends on lctcg_pkg; pushes printable characters into the job queue
module lctcg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  lctcg_pkg::cfg_t   cfg,
  input  logic              in_accept,
  input  logic              in_opcode,
  input  logic [7:0]        in_char_code,
  input  logic [7:0]        in_target_col,
  input  logic [7:0]        in_target_row,
  output logic              push,
  output lctcg_pkg::job_t   push_job
);
  import lctcg_pkg::*;

  logic [7:0]  col_r, col_nxt;
  logic [7:0]  row_r, row_nxt;
  logic        wrap;
  logic [7:0]  col_eff;
  logic [7:0]  row_eff;
  logic [15:0] prod;
  logic [8:0]  tab_sum;

  // row-full wrap and text offset of the character cell
  always_comb begin
    wrap    = (col_r >= cfg.row_width);
    col_eff = wrap ? 8'd0 : col_r;
    row_eff = wrap ? 8'(row_r + 8'd1) : row_r;
    prod    = {8'd0, row_eff} * {8'd0, cfg.row_width};
    tab_sum = {1'b0, col_r} + {1'b0, TAB_STEP};
  end

  // cursor update and job push
  always_comb begin
    col_nxt            = col_r;
    row_nxt            = row_r;
    push               = 1'b0;
    push_job.offs      = ADDR_W'(prod) + ADDR_W'(col_eff);
    push_job.glyph     = (in_char_code >= CHAR_HIGH) ? in_char_code
                                                     : 8'(in_char_code - GLYPH_OFFSET);
    push_job.with_attr = cfg.attr_en;
    if (in_accept) begin
      priority if (in_opcode == OP_MOVE) begin
        col_nxt = in_target_col;
        row_nxt = in_target_row;
      end else if (in_char_code == CHAR_LF) begin
        col_nxt = 8'd0;
        row_nxt = 8'(row_r + 8'd1);
      end else if (in_char_code == CHAR_CR) begin
        col_nxt = 8'd0;
      end else if (in_char_code == CHAR_TAB) begin
        if (tab_sum < {1'b0, cfg.row_width}) begin
          col_nxt = tab_sum[7:0];
        end
      end else begin
        push    = 1'b1;
        col_nxt = 8'(col_eff + 8'd1);
        row_nxt = row_eff;
      end
    end
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 8'd0;
      row_r <= 8'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* design/lctcg_fifo.sv */
// short job queue between front and back
// depends on lctcg_pkg for the job type; head is read combinationally from storage
module lctcg_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lctcg_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output lctcg_pkg::job_t head_job
);
  import lctcg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* design/lctcg_back.sv */
// back end: walks one job through its bus byte sequence, one beat per cycle while out_stall is low
// depends on lctcg_pkg; takes jobs from the queue head, drives the output register
module lctcg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  lctcg_pkg::cfg_t cfg,
  input  logic            head_valid,
  input  lctcg_pkg::job_t head_job,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [7:0]      out_bus_byte,
  output logic            out_is_command,
  output logic            out_last_of_run
);
  import lctcg_pkg::*;

  typedef enum logic [12:0] {
    ST_TXT_LO   = 13'b0000000000001,
    ST_TXT_HI   = 13'b0000000000010,
    ST_TXT_CMD  = 13'b0000000000100,
    ST_GLYPH    = 13'b0000000001000,
    ST_TXT_WR   = 13'b0000000010000,
    ST_ATR_LO   = 13'b0000000100000,
    ST_ATR_HI   = 13'b0000001000000,
    ST_ATR_CMD  = 13'b0000010000000,
    ST_ATR_BYTE = 13'b0000100000000,
    ST_ATR_WR   = 13'b0001000000000,
    ST_NXT_LO   = 13'b0010000000000,
    ST_NXT_HI   = 13'b0100000000000,
    ST_NXT_CMD  = 13'b1000000000000
  } step_t;

  step_t             step_r, step_nxt;
  logic              valid_r, valid_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              cmd_r, cmd_nxt;
  logic              last_r, last_nxt;
  logic              adv;
  logic [ADDR_W-1:0] txt_addr;
  logic [ADDR_W-1:0] atr_addr;
  logic [ADDR_W-1:0] nxt_addr;
  logic [7:0]        cur_byte;
  logic              cur_cmd;
  logic              cur_last;
  step_t             cur_next;

  assign out_valid       = valid_r;
  assign out_bus_byte    = byte_r;
  assign out_is_command  = cmd_r;
  assign out_last_of_run = last_r;

  // output register moves when empty or taken
  assign adv = !valid_r || !out_stall;

  // addresses of the current job
  always_comb begin
    txt_addr = cfg.text_home + head_job.offs;
    atr_addr = cfg.attr_home + head_job.offs;
    nxt_addr = atr_addr + ADDR_W'(cfg.row_width);
  end

  // byte of the current step
  always_comb begin
    cur_byte = 8'd0;
    cur_cmd  = 1'b0;
    cur_last = 1'b0;
    cur_next = ST_TXT_LO;
    unique case (step_r)
      ST_TXT_LO: begin
        cur_byte = txt_addr[7:0];
        cur_next = ST_TXT_HI;
      end
      ST_TXT_HI: begin
        cur_byte = txt_addr[15:8];
        cur_next = ST_TXT_CMD;
      end
      ST_TXT_CMD: begin
        cur_byte = CMD_ADDR_SET;
        cur_cmd  = 1'b1;
        cur_next = ST_GLYPH;
      end
      ST_GLYPH: begin
        cur_byte = head_job.glyph;
        cur_next = ST_TXT_WR;
      end
      ST_TXT_WR: begin
        cur_byte = CMD_DATA_WRITE;
        cur_cmd  = 1'b1;
        cur_last = !head_job.with_attr;
        cur_next = head_job.with_attr ? ST_ATR_LO : ST_TXT_LO;
      end
      ST_ATR_LO: begin
        cur_byte = atr_addr[7:0];
        cur_next = ST_ATR_HI;
      end
      ST_ATR_HI: begin
        cur_byte = atr_addr[15:8];
        cur_next = ST_ATR_CMD;
      end
      ST_ATR_CMD: begin
        cur_byte = CMD_ADDR_SET;
        cur_cmd  = 1'b1;
        cur_next = ST_ATR_BYTE;
      end
      ST_ATR_BYTE: begin
        cur_byte = cfg.attr_byte;
        cur_next = ST_ATR_WR;
      end
      ST_ATR_WR: begin
        cur_byte = CMD_DATA_WRITE;
        cur_cmd  = 1'b1;
        cur_next = ST_NXT_LO;
      end
      ST_NXT_LO: begin
        cur_byte = nxt_addr[7:0];
        cur_next = ST_NXT_HI;
      end
      ST_NXT_HI: begin
        cur_byte = nxt_addr[15:8];
        cur_next = ST_NXT_CMD;
      end
      ST_NXT_CMD: begin
        cur_byte = CMD_ADDR_SET;
        cur_cmd  = 1'b1;
        cur_last = 1'b1;
        cur_next = ST_TXT_LO;
      end
      default: begin
        cur_next = ST_TXT_LO;
      end
    endcase
  end

  // sequencer and output register update
  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    cmd_nxt   = cmd_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (adv) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        byte_nxt = cur_byte;
        cmd_nxt  = cur_cmd;
        last_nxt = cur_last;
        step_nxt = cur_next;
        pop      = cur_last;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_TXT_LO;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    cmd_r  <= cmd_nxt;
    last_r <= last_nxt;
  end

endmodule
